// ----- rtl/fcpq_pkg.sv -----
`timescale 1ns / 1ps

package fcpq_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;

    // operation codes on req.func
    localparam logic [1:0] FUNC_ENQ   = 2'd0;
    localparam logic [1:0] FUNC_SERVE = 2'd1;

    // status codes on rsp.status
    localparam logic [1:0] ST_SERVED  = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [7:0] THR_RESET = 8'd60;

    // class codes, lower is served first
    localparam logic [CLS_W-1:0] CLS_OLD_FLAG = 2'd0;
    localparam logic [CLS_W-1:0] CLS_FLAG     = 2'd1;
    localparam logic [CLS_W-1:0] CLS_OLD      = 2'd2;
    localparam logic [CLS_W-1:0] CLS_OTHER    = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] name_tag;
        logic [7:0]  person_age;
        logic        urgent;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_name;
        logic [7:0]  out_age;
        logic        out_urgent;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop;
        logic       respond;
        logic       use_mem;
        logic [1:0] status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       any_ready;
    } sts_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } fsm_state_t;

endpackage

// ----- rtl/fcpq_ctrl.sv -----
`timescale 1ns / 1ps

module fcpq_ctrl
    import fcpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.status  = ST_SERVED;
        busy        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (sts.func)
                    FUNC_ENQ:
                    begin
                        if (sts.full)
                        begin
                            cmd.respond = 1'b1;
                            cmd.status  = ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    FUNC_SERVE:
                    begin
                        if (sts.any_ready)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.respond = 1'b1;
                            cmd.status  = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_INVALID;
                    end
                endcase
            end
            S_READ:
            begin
                // read data registered last cycle
                cmd.respond = 1'b1;
                cmd.use_mem = 1'b1;
                cmd.status  = ST_SERVED;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_read_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (cmd.respond && cmd.use_mem))
        else $error("served read not answered");

endmodule

// ----- rtl/fcpq_dp.sv -----
`timescale 1ns / 1ps

module fcpq_dp
    import fcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_BITS   = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic       done,
    output rsp_t       rsp
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = CLS_W + PTR_W;
    localparam int MEM_D   = NUM_CLASSES * (1 << PTR_W);
    localparam int ENTRY_W = NAME_BITS + 9;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    req_t             req_reg;
    logic [7:0]       thr_reg;
    logic [PTR_W-1:0] head_reg [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_reg  [NUM_CLASSES];
    logic [ENTRY_W-1:0] mem [MEM_D];
    logic [ENTRY_W-1:0] rd_reg;
    logic             done_reg;
    rsp_t             rsp_reg;

    logic             is_old;
    logic [CLS_W-1:0] enq_cls;
    logic [CLS_W-1:0] srv_cls;
    logic             any_ready;
    logic [NUM_CLASSES-1:0] nonempty;

    // class of the pending enqueue
    always_comb
    begin
        is_old = req_reg.person_age >= thr_reg;
        if (req_reg.urgent)
        begin
            enq_cls = is_old ? CLS_OLD_FLAG : CLS_FLAG;
        end
        else
        begin
            enq_cls = is_old ? CLS_OLD : CLS_OTHER;
        end
    end

    // strict priority pick, class 0 first
    always_comb
    begin
        srv_cls = CLS_OTHER;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            nonempty[i] = cnt_reg[i] != '0;
        end
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                srv_cls = CLS_W'(i);
            end
        end
        any_ready = |nonempty;
    end

    assign sts.func      = req_reg.func;
    assign sts.full      = cnt_reg[enq_cls] == CNT_FULL;
    assign sts.any_ready = any_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                if (cmd.push && enq_cls == CLS_W'(i))
                begin
                    tail_reg[i] <= (tail_reg[i] == PTR_LAST) ? '0 : tail_reg[i] + 1'b1;
                    cnt_reg[i]  <= cnt_reg[i] + 1'b1;
                end
                if (cmd.pop && srv_cls == CLS_W'(i))
                begin
                    head_reg[i] <= (head_reg[i] == PTR_LAST) ? '0 : head_reg[i] + 1'b1;
                    cnt_reg[i]  <= cnt_reg[i] - 1'b1;
                end
            end
        end
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[{enq_cls, tail_reg[enq_cls]}] <= {req_reg.name_tag[NAME_BITS-1:0],
                                                 req_reg.person_age, req_reg.urgent};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            rd_reg <= mem[ADDR_W'({srv_cls, head_reg[srv_cls]})];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            rsp_reg.status <= cmd.status;
            if (cmd.use_mem)
            begin
                rsp_reg.out_name   <= 64'(rd_reg[ENTRY_W-1:9]);
                rsp_reg.out_age    <= rd_reg[8:1];
                rsp_reg.out_urgent <= rd_reg[0];
            end
            else
            begin
                rsp_reg.out_name   <= '0;
                rsp_reg.out_age    <= '0;
                rsp_reg.out_urgent <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (cnt_reg[enq_cls] != CNT_FULL))
        else $error("push into a full class");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (cnt_reg[srv_cls] != '0))
        else $error("pop from an empty class");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in one cycle");

    for (genvar g = 0; g < NUM_CLASSES; g++)
    begin : g_cnt_chk
        a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
            cnt_reg[g] <= CNT_FULL)
            else $error("class fill count above depth");
    end

endmodule

// ----- rtl/four_class_priority_queue_top.sv -----
`timescale 1ns / 1ps

// Channel   Signals                      Transaction when
// request   start, busy, req (req_t)     start && !busy at rising edge
// result    done, rsp (rsp_t)            done high (one cycle, no backpressure)
// config    cfg_valid, cfg_ready,        cfg_valid && cfg_ready at rising edge
//           cfg_data (age threshold)
//
// An enqueue holds busy through the execute state after the accepting edge. A
// serve holds busy through execute, and if it finds an entry also through the
// registered read of the entry memory. Every answer has done high in the cycle
// right after the last busy cycle of its request.
// One request is in flight at a time; busy covers it. The result register
// lets the next request be accepted while a result is still on the ports.
// rst_n is asynchronous, active low: all class pointers and fill counts clear,
// the threshold returns to 60, the entry memory is left as is.
// The receiver cannot stall; cfg_ready is always high.

module four_class_priority_queue_top
    import fcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_BITS   = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    output logic       done,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencing: accept, execute, optional memory read
    fcpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // class select, pointers, entry memory, result register
    fcpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NAME_BITS   (NAME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import fcpq_pkg::*;
();

    localparam int         QUEUE_DEPTH  = 16;
    localparam int         SETTLE_CYC   = 8;      // covers the serve path with margin
    localparam int         GAP_PCT      = 24;
    localparam int         REQ_W        = $bits(req_t);
    localparam logic [1:0] FUNC_BAD_LO  = 2'd2;   // both unused opcodes answer invalid
    localparam logic [1:0] FUNC_BAD_HI  = 2'd3;

    // Scoreboard: keeps its own copy of the four class FIFOs and the threshold,
    // predicts the answer of every accepted request, checks answers in order.
    class fcpq_scoreboard;
        logic [7:0] threshold;
        req_t       class_lanes [NUM_CLASSES][$];
        rsp_t       awaited_answers[$];
        int         mismatch_count;

        function new();
            threshold      = THR_RESET;
            mismatch_count = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        function void note_request(req_t item);
            logic [1:0] cls;
            logic       is_old;
            logic       found;
            req_t       head;
            rsp_t       answer;
            answer = '0;
            case (item.func)
                FUNC_ENQ:
                begin
                    is_old = (item.person_age >= threshold);
                    if (is_old && item.urgent)
                        cls = CLS_OLD_FLAG;
                    else if (item.urgent)
                        cls = CLS_FLAG;
                    else if (is_old)
                        cls = CLS_OLD;
                    else
                        cls = CLS_OTHER;
                    if (class_lanes[cls].size() >= QUEUE_DEPTH)
                    begin
                        answer.status = ST_FULL;
                        awaited_answers.push_back(answer);
                    end
                    else
                    begin
                        class_lanes[cls].push_back(item);
                    end
                end
                FUNC_SERVE:
                begin
                    // strict priority: lowest class number that holds anything
                    found = 1'b0;
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        if (!found && class_lanes[c].size() != 0)
                        begin
                            found             = 1'b1;
                            head              = class_lanes[c].pop_front();
                            answer.status     = ST_SERVED;
                            answer.out_name   = head.name_tag;
                            answer.out_age    = head.person_age;
                            answer.out_urgent = head.urgent;
                        end
                    end
                    if (!found)
                        answer.status = ST_EMPTY;
                    awaited_answers.push_back(answer);
                end
                default:
                begin
                    answer.status = ST_INVALID;
                    awaited_answers.push_back(answer);
                end
            endcase
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (awaited_answers.size() == 0)
            begin
                report($sformatf("result with nothing pending, status %0d", got.status));
                return;
            end
            want = awaited_answers.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.out_name !== want.out_name)
                report($sformatf("out_name %h, want %h", got.out_name, want.out_name));
            if (got.out_age !== want.out_age)
                report($sformatf("out_age %0d, want %0d", got.out_age, want.out_age));
            if (got.out_urgent !== want.out_urgent)
                report($sformatf("out_urgent %b, want %b", got.out_urgent, want.out_urgent));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       done;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    bit             idle_gaps;
    fcpq_scoreboard sb = new();

    four_class_priority_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NAME_BITS   (64)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Monitor. Everything is sampled at the rising edge, so it sees the values
    // that decided each transaction there. The result is checked before the
    // request of the same edge is noted; a request cannot answer on the edge
    // that accepts it, so the order only keeps the log readable.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(rsp);
            if (start && !busy)
                sb.note_request(req);
            if (cfg_valid && cfg_ready)
                sb.threshold = cfg_data;
        end
    end

    // One request transaction. start is left high after acceptance: the next
    // call either keeps it high or drops it for a gap, never both in one step.
    task automatic issue_request(input req_t item);
        if (idle_gaps)
        begin
            while ($urandom_range(99) < GAP_PCT)
            begin
                start <= 1'b0;
                req   <= REQ_W'({$urandom, $urandom, $urandom});
                @(posedge clk);
            end
        end
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Quiesce: drop start, wait for every predicted answer and for busy to
    // fall, then wait on with margin since a plain enqueue answers nothing.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited_answers.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Threshold write, only with the block idle.
    task automatic write_threshold(input logic [7:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t make_req(input logic [1:0] func, input logic [63:0] name,
                                      input logic [7:0] age, input logic urgent);
        req_t item;
        item.func       = func;
        item.name_tag   = name;
        item.person_age = age;
        item.urgent     = urgent;
        return item;
    endfunction

    // Random traffic. enq_pct sets the fill pressure; most enqueues are aimed
    // at hot_cls so that class reaches full and drops, the rest spread out.
    task automatic random_traffic(input int count, input int enq_pct,
                                  input logic [1:0] hot_cls);
        req_t       item;
        int         roll;
        int         thr;
        logic [1:0] cls;
        logic       want_old;
        for (int n = 0; n < count; n++)
        begin
            item.name_tag   = {$urandom, $urandom};
            item.person_age = 8'($urandom_range(255));
            item.urgent     = 1'($urandom_range(1));
            roll            = $urandom_range(99);
            if (roll < 5)
            begin
                item.func = ($urandom_range(1) != 0) ? FUNC_BAD_HI : FUNC_BAD_LO;
            end
            else if (roll < 5 + enq_pct)
            begin
                item.func = FUNC_ENQ;
                cls       = ($urandom_range(99) < 60) ? hot_cls : 2'($urandom_range(3));
                thr       = int'(sb.threshold);
                want_old  = (cls == CLS_OLD_FLAG || cls == CLS_OLD);
                item.urgent = (cls == CLS_OLD_FLAG || cls == CLS_FLAG);
                if ($urandom_range(3) == 0)
                    item.person_age = 8'($urandom_range(255));
                else if (want_old)
                    item.person_age = 8'($urandom_range(255, thr));
                else if (thr != 0)
                    item.person_age = 8'($urandom_range(thr - 1, 0));
            end
            else
            begin
                item.func = FUNC_SERVE;
            end
            issue_request(item);
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        idle_gaps = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset threshold of 60.
        issue_request(make_req(FUNC_SERVE, '1, 8'hFF, 1'b1));          // serve while empty
        issue_request(make_req(FUNC_BAD_LO, '1, 8'hFF, 1'b1));         // invalid op
        issue_request(make_req(FUNC_BAD_HI, '0, 8'h00, 1'b0));         // invalid op
        issue_request(make_req(FUNC_ENQ, 64'h0, 8'd59, 1'b0));         // just below: other
        issue_request(make_req(FUNC_ENQ, '1, 8'd60, 1'b0));            // at threshold: old
        issue_request(make_req(FUNC_ENQ, 64'h4164_6120_4c6f_7665, 8'd0, 1'b1));   // flagged
        issue_request(make_req(FUNC_ENQ, 64'h8000_0000_0000_0001, 8'd255, 1'b1)); // old+flag
        issue_request(make_req(FUNC_BAD_HI, '1, 8'hFF, 1'b1));         // invalid, no state change
        issue_request(make_req(FUNC_ENQ, 64'h0123_4567_89ab_cdef, 8'd255, 1'b0)); // old
        issue_request(make_req(FUNC_ENQ, 64'hfedc_ba98_7654_3210, 8'd59, 1'b1));  // flagged
        issue_request(make_req(FUNC_ENQ, 64'h5555_5555_5555_5555, 8'd1, 1'b0));   // other
        issue_request(make_req(FUNC_ENQ, 64'haaaa_aaaa_aaaa_aaaa, 8'd254, 1'b1)); // old+flag
        // drain: priority order across classes, FIFO order within a class
        for (int n = 0; n < 9; n++)
            issue_request(make_req(FUNC_SERVE, {$urandom, $urandom}, 8'($urandom), 1'b0));

        // Threshold at the top: only age 255 is old. Fill old+flag to full.
        write_threshold(8'd255);
        random_traffic(90, 70, CLS_OLD_FLAG);
        random_traffic(60, 25, CLS_FLAG);

        // Threshold zero: everything is old. Long stretch with no idling.
        write_threshold(8'd0);
        idle_gaps = 1'b0;
        random_traffic(80, 65, CLS_OLD);
        idle_gaps = 1'b1;
        random_traffic(50, 20, CLS_OTHER);

        write_threshold(8'($urandom_range(1, 254)));
        random_traffic(80, 55, 2'($urandom_range(3)));

        // back to the reset value, then drain
        write_threshold(THR_RESET);
        random_traffic(60, 50, CLS_OTHER);
        random_traffic(40, 10, CLS_FLAG);

        settle();
        if (sb.awaited_answers.size() != 0)
            sb.report($sformatf("%0d answers never arrived", sb.awaited_answers.size()));
        if (sb.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
